/* sv/ilb_pkg.sv */
// Package for the integer list buffer: widths, operation codes, word types
// and the sequencer state type. No dependencies.
`default_nettype none

package ilb_pkg;

    localparam int DEPTH  = 32;                  // store entries
    localparam int ADDR_W = $clog2(DEPTH);       // slot index width
    localparam int LEN_W  = $clog2(DEPTH + 1);   // fill count width
    localparam int DATA_W = 32;

    localparam logic [2:0] FUNC_ADD     = 3'd0;
    localparam logic [2:0] FUNC_RM_FAST = 3'd1;
    localparam logic [2:0] FUNC_RM_STAB = 3'd2;
    localparam logic [2:0] FUNC_FIND_FW = 3'd3;
    localparam logic [2:0] FUNC_FIND_BW = 3'd4;
    localparam logic [2:0] FUNC_CLEAR   = 3'd5;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] value;
        logic [ADDR_W-1:0]        position_in;
    } t_in_word;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] position_out;
        logic [LEN_W-1:0]  fill_count;
    } t_out_word;

    typedef logic [LEN_W-1:0] t_cfg_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* sv/ilb_stream_if.sv */
// Valid/ready channel interface with a typed payload.
// Used for the item, result and configuration channels; no dependencies.
`default_nettype none

interface ilb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/integer_list_buffer.sv */
// Top level of the integer list buffer: a bounded list of 32-bit words kept in
// a one-port-read, one-port-write synchronous memory. Depends on ilb_pkg and
// ilb_stream_if.
//
//   Channel  Dir  Payload                              Accepted when
//   i_in     in   func, value, position_in             valid && ready
//   o_out    out  ok, position_out, fill_count         valid && ready
//   i_cfg    in   capacity_limit (6 bits)              valid && ready
//
// One item is worked at a time. Add, clear and unused codes go from acceptance
// straight to the final state with no memory reads. Fast remove reads the last
// entry and writes it into the slot; a search walks the list and stable remove
// the entries above the slot, reading one slot per cycle through the single
// memory read port. i_rst_n is synchronous and active low; it
// empties the list and sets the capacity to 32, while the memory itself keeps
// whatever it held. A stalled result word holds the sequencer in its final
// state, and no new word is taken on i_in until the previous result has been
// loaded into the output register.
`default_nettype none

module integer_list_buffer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    ilb_stream_if.sink           i_in,
    ilb_stream_if.source         o_out,
    ilb_stream_if.sink           i_cfg
);
    import ilb_pkg::*;

    // Storage.
    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    // Sequencer state and control.
    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_len, n_len;
    t_cfg_word           r_cap;
    logic                r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [ADDR_W-1:0]   r_last, n_last;
    logic                r_up, n_up;

    // Latched item and working result.
    logic [2:0]               r_func, n_func;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [ADDR_W-1:0]        r_pos, n_pos;
    logic                     r_ok, n_ok;
    logic [ADDR_W-1:0]        r_found, n_found;

    // Output register.
    logic      r_out_valid, n_out_valid;
    t_out_word r_out_data, n_out_data;

    // Memory port controls.
    logic                     mem_re, mem_we;
    logic [ADDR_W-1:0]        mem_ra, mem_wa;
    logic signed [DATA_W-1:0] mem_wd;

    logic              in_acc;
    logic              out_free;
    logic [LEN_W-1:0]  len_m1;
    logic [ADDR_W-1:0] last_slot;
    logic              can_add;
    logic              pos_ok;
    logic              is_search;
    logic              hit;
    logic              need_scan;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign len_m1    = r_len - LEN_W'(1);
    assign last_slot = len_m1[ADDR_W-1:0];

    // The capacity in use is the smaller of the register and the store depth.
    assign can_add = (r_len < r_cap) && (r_len < LEN_W'(DEPTH));
    assign pos_ok  = {1'b0, i_in.data.position_in} < r_len;

    assign is_search = (r_func == FUNC_FIND_FW) || (r_func == FUNC_FIND_BW);
    // A search stops at the first match in its walking order.
    assign hit = r_rd_vld && is_search && (r_rdata == r_value);

    // Decide at acceptance whether the item needs any memory reads. A fast
    // remove of the last slot and a stable remove of the last slot only drop
    // the fill count.
    always_comb begin
        need_scan = 1'b0;
        case (i_in.data.func)
            FUNC_RM_FAST: need_scan = pos_ok && (i_in.data.position_in != last_slot);
            FUNC_RM_STAB: need_scan = pos_ok && (i_in.data.position_in < last_slot);
            FUNC_FIND_FW,
            FUNC_FIND_BW: need_scan = (r_len != '0);
            default:      need_scan = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = need_scan ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                if (hit) begin
                    n_state = S_DONE;
                end else if (r_idx == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory port controls.
    always_comb begin
        n_len       = r_len;
        n_rd_vld    = 1'b0;
        n_rd_addr   = r_rd_addr;
        n_idx       = r_idx;
        n_last      = r_last;
        n_up        = r_up;
        n_func      = r_func;
        n_value     = r_value;
        n_pos       = r_pos;
        n_ok        = r_ok;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_re      = 1'b0;
        mem_ra      = r_idx;
        mem_we      = 1'b0;
        mem_wa      = r_pos;
        mem_wd      = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func  = i_in.data.func;
                    n_value = i_in.data.value;
                    n_pos   = i_in.data.position_in;
                    n_ok    = 1'b0;
                    n_found = '0;
                    n_up    = 1'b1;
                    case (i_in.data.func)
                        FUNC_ADD: begin
                            if (can_add) begin
                                mem_we = 1'b1;
                                mem_wa = r_len[ADDR_W-1:0];
                                mem_wd = i_in.data.value;
                                n_len  = r_len + LEN_W'(1);
                                n_ok   = 1'b1;
                            end
                        end
                        FUNC_RM_FAST: begin
                            // The last entry is read and written into the slot.
                            if (pos_ok) begin
                                n_len  = len_m1;
                                n_ok   = 1'b1;
                                n_idx  = last_slot;
                                n_last = last_slot;
                            end
                        end
                        FUNC_RM_STAB: begin
                            // Entries above the slot each move down one place.
                            if (pos_ok) begin
                                n_len  = len_m1;
                                n_ok   = 1'b1;
                                n_idx  = i_in.data.position_in + ADDR_W'(1);
                                n_last = last_slot;
                            end
                        end
                        FUNC_FIND_FW: begin
                            n_idx  = '0;
                            n_last = last_slot;
                        end
                        FUNC_FIND_BW: begin
                            n_idx  = last_slot;
                            n_last = '0;
                            n_up   = 1'b0;
                        end
                        FUNC_CLEAR: begin
                            n_len = '0;
                            n_ok  = 1'b1;
                        end
                        default: n_ok = 1'b0;
                    endcase
                end
            end
            S_READ: begin
                mem_re    = 1'b1;
                mem_ra    = r_idx;
                n_rd_vld  = 1'b1;
                n_rd_addr = r_idx;
                if (r_idx != r_last) begin
                    n_idx = r_up ? r_idx + ADDR_W'(1) : r_idx - ADDR_W'(1);
                end
            end
            default: ;
        endcase

        // Read data arrives in the cycle after its address, in both scan states.
        if ((r_state == S_READ || r_state == S_DRAIN) && r_rd_vld) begin
            if (hit) begin
                n_ok    = 1'b1;
                n_found = r_rd_addr;
            end
            if (r_func == FUNC_RM_STAB) begin
                mem_we = 1'b1;
                mem_wa = r_rd_addr - ADDR_W'(1);
            end else if (r_func == FUNC_RM_FAST) begin
                mem_we = 1'b1;
                mem_wa = r_pos;
            end
        end

        if (r_state == S_DONE && out_free) begin
            n_out_valid             = 1'b1;
            n_out_data.ok           = r_ok;
            n_out_data.position_out = r_found;
            n_out_data.fill_count   = r_len;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cap       <= LEN_W'(32);
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_idx      <= n_idx;
        r_last     <= n_last;
        r_up       <= n_up;
        r_func     <= n_func;
        r_value    <= n_value;
        r_pos      <= n_pos;
        r_ok       <= n_ok;
        r_found    <= n_found;
        r_out_data <= n_out_data;
    end

    // The fill count never exceeds the store depth.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(DEPTH))
        else $error("fill count above store depth");

    // Every accepted word takes the sequencer out of the idle state in the cycle after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accepting a word");

    // A result word is only loaded from the final sequencer state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the final state");

    // Memory writes during a scan only occur with read data in hand.
    a_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != S_IDLE) |-> r_rd_vld)
        else $error("scan write without read data");

endmodule

`default_nettype wire

/* dv/list_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the integer list buffer: watches the item, result and
// capacity channels, predicts each result word and compares it field by field.
// Depends on ilb_pkg.

module list_result_checker
    import ilb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  t_in_word  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  t_out_word out_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  t_cfg_word cfg_data,
    output int        error_count,
    output int        outstanding
);

    logic [DATA_W-1:0] list_words [DEPTH];
    int                list_fill;
    t_cfg_word         cap_reg;
    t_out_word         expected_words [$];
    int                errs;

    // Applies one operation to the shadow list and returns the result word.
    function automatic t_out_word apply_op(t_in_word w);
        t_out_word r;
        int        cap_use;
        int        i;
        r = '0;
        cap_use = (cap_reg < DEPTH) ? int'(cap_reg) : DEPTH;
        case (w.func)
            FUNC_ADD: begin
                if (list_fill < cap_use) begin
                    list_words[list_fill] = w.value;
                    list_fill++;
                    r.ok = 1'b1;
                end
            end
            FUNC_RM_FAST: begin
                if (int'(w.position_in) < list_fill) begin
                    list_fill--;
                    list_words[w.position_in] = list_words[list_fill];
                    r.ok = 1'b1;
                end
            end
            FUNC_RM_STAB: begin
                if (int'(w.position_in) < list_fill) begin
                    list_fill--;
                    for (i = int'(w.position_in) + 1; i <= list_fill; i++)
                        list_words[i-1] = list_words[i];
                    r.ok = 1'b1;
                end
            end
            FUNC_FIND_FW: begin
                for (i = 0; i < list_fill; i++) begin
                    if (list_words[i] == w.value) begin
                        r.ok = 1'b1;
                        r.position_out = i[ADDR_W-1:0];
                        break;
                    end
                end
            end
            FUNC_FIND_BW: begin
                for (i = list_fill - 1; i >= 0; i--) begin
                    if (list_words[i] == w.value) begin
                        r.ok = 1'b1;
                        r.position_out = i[ADDR_W-1:0];
                        break;
                    end
                end
            end
            FUNC_CLEAR: begin
                list_fill = 0;
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.fill_count = list_fill[LEN_W-1:0];
        return r;
    endfunction

    always @(posedge clk) begin : monitor
        t_out_word want;
        if (!rst_n) begin
            list_fill = 0;
            cap_reg = t_cfg_word'(DEPTH);
            expected_words.delete();
            errs = 0;
        end else begin
            // A result word leaving in the same cycle as a new item enters
            // belongs to an earlier item, so it is checked first.
            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    errs++;
                    $error("unexpected result word: ok %0d position_out %0d fill_count %0d",
                           out_data.ok, out_data.position_out, out_data.fill_count);
                end else begin
                    want = expected_words.pop_front();
                    if (out_data.ok !== want.ok) begin
                        errs++;
                        $error("ok: expected %0d, actual %0d", want.ok, out_data.ok);
                    end
                    if (out_data.position_out !== want.position_out) begin
                        errs++;
                        $error("position_out: expected %0d, actual %0d",
                               want.position_out, out_data.position_out);
                    end
                    if (out_data.fill_count !== want.fill_count) begin
                        errs++;
                        $error("fill_count: expected %0d, actual %0d",
                               want.fill_count, out_data.fill_count);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                cap_reg = cfg_data;
            if (in_valid && in_ready)
                expected_words.push_back(apply_op(in_data));
        end
        error_count <= errs;
        outstanding <= expected_words.size();
    end

endmodule

/* dv/integer_list_buffer_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the integer list buffer: clock, reset, stimulus and verdict.
// Depends on ilb_pkg, ilb_stream_if, integer_list_buffer and list_result_checker.

module integer_list_buffer_tb;
    import ilb_pkg::*;

    // The two codes the block does not define; they must leave the list alone.
    localparam logic [2:0] FUNC_UNUSED_A = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_B = 3'd7;

    localparam int IDLE_MAX        = 18;
    // Longest operation is a full search.
    localparam int SETTLE_CYCLES   = DEPTH + 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 150;

    logic clk;
    logic rst_n;

    ilb_stream_if #(.T(t_in_word))  in_ch ();
    ilb_stream_if #(.T(t_out_word)) out_ch ();
    ilb_stream_if #(.T(t_cfg_word)) cfg_ch ();

    int fail_count;
    int outstanding;
    int quiet_cycles;
    int cap_now;

    // While set, both sides insert random idle bursts; cleared for the last phase.
    bit stall_on;

    // Search keys are mostly drawn from this pool so that finds actually hit.
    logic [DATA_W-1:0] value_pool [8];

    // Capacity settings, one per phase. The list is never cleared between
    // phases, so going from a large capacity to a small one leaves the fill
    // count above the capacity. 63 and 0 are the extremes of the register;
    // 33 and 63 also exercise values above the store depth.
    t_cfg_word phase_caps [NUM_PHASES] = '{6'd63, 6'd1, 6'd0, 6'd2, 6'd32, 6'd5,
                                           6'd17, 6'd33, 6'd3, 6'd31, 6'd24, 6'd32};

    integer_list_buffer u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    list_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_data     (in_ch.data),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_data    (out_ch.data),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_data    (cfg_ch.data),
        .error_count (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a run in which no word moves on any channel for this long has
    // hung. Correct runs stay far below the limit, even through the settle
    // pauses between phases.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: ready is held high in runs of random length, broken by
    // random stall bursts while stalling is enabled.
    initial begin
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (stall_on && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Presents one word on the item channel and returns at the edge that
    // accepts it. Valid is left high so that a following word can go out
    // back to back; whoever stops sending lowers it.
    task automatic send_op(logic [2:0] f, logic [DATA_W-1:0] v, logic [ADDR_W-1:0] p);
        t_in_word w;
        w.func        = f;
        w.value       = v;
        w.position_in = p;
        if (stall_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Stops sending and waits until every expected result has arrived, then
    // gives the block time to finish anything still in flight. The first edge
    // is always waited so that the checker's count includes the last word.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Capacity is only changed while the block is idle.
    task automatic write_capacity(t_cfg_word c);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= c;
        cap_now = int'(c);
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random operation mix. Adds outweigh removes so the list tends to fill
    // up to the capacity, which is where the full-list and search-length
    // behavior lives. Slots are mostly chosen inside the capacity so removes
    // usually hit a held entry; the rest cover the whole slot range.
    task automatic send_random_op();
        int                roll;
        int                lim;
        logic [2:0]        f;
        logic [DATA_W-1:0] v;
        logic [ADDR_W-1:0] p;
        roll = $urandom_range(0, 199);
        if (roll < 80)
            f = FUNC_ADD;
        else if (roll < 105)
            f = FUNC_RM_FAST;
        else if (roll < 130)
            f = FUNC_RM_STAB;
        else if (roll < 160)
            f = FUNC_FIND_FW;
        else if (roll < 190)
            f = FUNC_FIND_BW;
        else if (roll < 194)
            f = FUNC_CLEAR;
        else if (roll < 197)
            f = FUNC_UNUSED_A;
        else
            f = FUNC_UNUSED_B;
        if ($urandom_range(0, 3) != 0)
            v = value_pool[$urandom_range(0, 7)];
        else
            v = $urandom();
        lim = (cap_now == 0) ? 1 : ((cap_now > DEPTH) ? DEPTH : cap_now);
        if ($urandom_range(0, 3) != 0)
            p = ADDR_W'($urandom_range(0, lim - 1));
        else
            p = ADDR_W'($urandom_range(0, DEPTH - 1));
        send_op(f, v, p);
    endtask

    initial begin
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        rst_n        <= 1'b0;
        stall_on     = 1'b1;
        cap_now      = DEPTH;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset capacity of 32.
        // Searches and removes on an empty list must all fail.
        send_op(FUNC_FIND_FW, 32'h0000_0000, 5'd0);
        send_op(FUNC_FIND_BW, 32'h0000_0000, 5'd0);
        send_op(FUNC_RM_FAST, 32'h0000_0000, 5'd0);
        send_op(FUNC_RM_STAB, 32'hFFFF_FFFF, 5'd31);
        // Fill with the extremes of the value range and a duplicate.
        send_op(FUNC_ADD, 32'h8000_0000, 5'd0);
        send_op(FUNC_ADD, 32'h7FFF_FFFF, 5'd0);
        send_op(FUNC_ADD, 32'h0000_0000, 5'd0);
        send_op(FUNC_ADD, 32'hFFFF_FFFF, 5'd0);
        send_op(FUNC_ADD, 32'h7FFF_FFFF, 5'd0);
        send_op(FUNC_ADD, 32'h5A5A_5A5A, 5'd0);
        // The duplicate tells find-first from find-last; the last one misses.
        send_op(FUNC_FIND_FW, 32'h7FFF_FFFF, 5'd0);
        send_op(FUNC_FIND_BW, 32'h7FFF_FFFF, 5'd0);
        send_op(FUNC_FIND_FW, 32'hFFFF_FFFF, 5'd31);
        send_op(FUNC_FIND_BW, 32'h1234_5678, 5'd0);
        // Stable remove of the head, a remove of a slot not held, a fast
        // remove from the middle and a stable remove of the tail.
        send_op(FUNC_RM_STAB, 32'h0000_0000, 5'd0);
        send_op(FUNC_RM_FAST, 32'h0000_0000, 5'd31);
        send_op(FUNC_RM_FAST, 32'h0000_0000, 5'd1);
        send_op(FUNC_RM_STAB, 32'h0000_0000, 5'd3);
        // Undefined codes with every value and position bit set.
        send_op(FUNC_UNUSED_A, 32'hFFFF_FFFF, 5'd31);
        send_op(FUNC_UNUSED_B, 32'hFFFF_FFFF, 5'd31);
        // Clear, then a search on the emptied list and a fresh add.
        send_op(FUNC_CLEAR, 32'h0000_0000, 5'd0);
        send_op(FUNC_FIND_FW, 32'h7FFF_FFFF, 5'd0);
        send_op(FUNC_ADD, 32'h0000_0001, 5'd0);

        // Random phases, one capacity setting each. The last phase runs with
        // no idling on either side.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1)
                stall_on = 1'b0;
            write_capacity(phase_caps[ph]);
            value_pool[0] = 32'h8000_0000;
            value_pool[1] = 32'h7FFF_FFFF;
            for (int k = 2; k < 8; k++)
                value_pool[k] = $urandom();
            repeat (ITEMS_PER_PHASE) send_random_op();
        end

        settle();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
